>>> sv/itf_pkg.sv
// Shared types, character constants and helpers for the integer text formatter.
package itf_pkg;

    typedef enum logic [1:0] {
        CMD_SDEC = 2'd0,
        CMD_UDEC = 2'd1,
        CMD_HEX  = 2'd2,
        CMD_CHAR = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SETUP,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic setup;
        logic emit;
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic dig_done;
        logic quo_zero;
        logic cnt_zero;
        logic out_free;
    } dp_stat_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [4:0] RADIX_DEC = 5'd10;
    localparam int CHUNK_BITS = 8;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {4'd0, d};
        end
        else
        begin
            c = CH_LOW_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

>>> sv/itf_ctrl.sv
// Controller state machine: sequences load, digit conversion, setup and emission.
module itf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output itf_pkg::ctl_cmd_t cmd,
    input  itf_pkg::dp_stat_t st
);
    import itf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (st.dig_done && st.quo_zero)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.out_free && st.cnt_zero)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            S_EMIT:
            begin
                cmd.emit = st.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DIV))
        else $error("accepted beat did not start digit conversion");

endmodule

>>> sv/itf_dp.sv
// Datapath: operand, digit generation, digit store, emit counter and output register.
module itf_dp #(
    parameter int MAX_WIDTH  = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  itf_pkg::ctl_cmd_t cmd,
    output itf_pkg::dp_stat_t st,
    input  logic [1:0]        command,
    input  logic [31:0]       value,
    input  logic              zero_pad,
    input  logic [5:0]        min_width,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_char,
    output logic              last
);
    import itf_pkg::*;

    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int DIG_N      = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIG_IW     = $clog2(DIG_N);
    localparam int NDW        = $clog2(DIG_N + 1);
    localparam int NCH        = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int QW         = NCH * CHUNK_BITS;
    localparam int CW         = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int TOT_MAX    = (MAX_WIDTH > DIG_N + 1) ? MAX_WIDTH : DIG_N + 1;
    localparam int CTW        = $clog2(TOT_MAX + 1);
    localparam int EXT_W      = VALUE_BITS + 32;

    // Control registers
    logic [NDW-1:0]  ndig_reg, ndig_next;
    logic [CW-1:0]   chunk_reg, chunk_next;
    logic [CTW-1:0]  cnt_reg, cnt_next;
    logic            first_reg, first_next;
    logic            out_valid_reg, out_valid_next;

    // Payload registers
    cmd_e_t          cmd_reg;
    logic            neg_reg;
    logic            zp_reg;
    logic [CTW-1:0]  width_reg;
    logic [QW-1:0]   q_reg, q_next;
    logic [3:0]      rem_reg, rem_next;
    logic [7:0]      dig_reg [DIG_N];
    logic [7:0]      out_char_reg;
    logic            last_reg;

    // Operand after masking to VALUE_BITS
    logic [EXT_W-1:0]      val_ext;
    logic [VALUE_BITS-1:0] val;
    logic [VALUE_BITS-1:0] mag;
    logic                  in_neg;
    logic [6:0]            width_sat;

    assign val_ext   = {{VALUE_BITS{1'b0}}, value};
    assign val       = val_ext[VALUE_BITS-1:0];
    assign mag       = VALUE_BITS'(0) - val;
    assign in_neg    = (cmd_e_t'(command) == CMD_SDEC) && val[VALUE_BITS-1];
    assign width_sat = ({1'b0, min_width} > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH)
                                                           : {1'b0, min_width};

    // Divide the top chunk of the quotient by ten, one bit per step
    logic [CHUNK_BITS-1:0] chunk_top;
    logic [CHUNK_BITS-1:0] qbits;
    logic [4:0]            r;
    logic [QW-1:0]         q_dec;

    assign chunk_top = q_reg[QW-1 -: CHUNK_BITS];

    always_comb
    begin
        r     = {1'b0, rem_reg};
        qbits = '0;
        for (int j = CHUNK_BITS - 1; j >= 0; j--)
        begin
            r = {r[3:0], chunk_top[j]};
            if (r >= RADIX_DEC)
            begin
                r        = r - RADIX_DEC;
                qbits[j] = 1'b1;
            end
        end
    end

    assign q_dec = QW'({q_reg, qbits});

    // Digit generation
    logic       dig_wr;
    logic [7:0] dig_wdata;
    logic       quo_zero;

    always_comb
    begin
        q_next     = q_reg;
        rem_next   = rem_reg;
        chunk_next = chunk_reg;
        dig_wr     = 1'b0;
        dig_wdata  = CH_ZERO;
        quo_zero   = 1'b0;
        if (cmd.load)
        begin
            q_next     = in_neg ? QW'(mag) : QW'(val);
            rem_next   = '0;
            chunk_next = '0;
        end
        else if (cmd.div_step)
        begin
            case (cmd_reg)
                CMD_HEX:
                begin
                    q_next    = q_reg >> 4;
                    dig_wr    = 1'b1;
                    dig_wdata = digit_char(q_reg[3:0]);
                    quo_zero  = ((q_reg >> 4) == '0);
                end
                CMD_CHAR:
                begin
                    dig_wr    = 1'b1;
                    dig_wdata = q_reg[7:0];
                    quo_zero  = 1'b1;
                end
                default:
                begin
                    q_next = q_dec;
                    if (chunk_reg == CW'(NCH - 1))
                    begin
                        dig_wr     = 1'b1;
                        dig_wdata  = digit_char(r[3:0]);
                        quo_zero   = (q_dec == '0);
                        rem_next   = '0;
                        chunk_next = '0;
                    end
                    else
                    begin
                        rem_next   = r[3:0];
                        chunk_next = chunk_reg + CW'(1);
                    end
                end
            endcase
        end
    end

    // Character at the current emit position
    logic [CTW-1:0] len;
    logic [CTW-1:0] total;
    logic [CTW-1:0] ndig_ext;
    logic [7:0]     pad_char;
    logic [7:0]     emit_char;

    assign ndig_ext = CTW'(ndig_reg);
    assign len      = ndig_ext + CTW'(neg_reg);
    assign total    = (width_reg > len) ? width_reg : len;
    assign pad_char = (zp_reg && (cmd_reg != CMD_CHAR)) ? CH_ZERO : CH_SPACE;

    always_comb
    begin
        if (cnt_reg < ndig_ext)
        begin
            emit_char = dig_reg[cnt_reg[DIG_IW-1:0]];
        end
        else if (neg_reg && ((zp_reg && first_reg) || (!zp_reg && (cnt_reg == ndig_ext))))
        begin
            emit_char = CH_MINUS;
        end
        else
        begin
            emit_char = pad_char;
        end
    end

    always_comb
    begin
        ndig_next      = ndig_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            ndig_next = '0;
        end
        else if (dig_wr)
        begin
            ndig_next = ndig_reg + NDW'(1);
        end
        if (cmd.setup)
        begin
            cnt_next   = total - CTW'(1);
            first_next = 1'b1;
        end
        else if (cmd.emit)
        begin
            cnt_next   = cnt_reg - CTW'(1);
            first_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ndig_reg      <= '0;
            chunk_reg     <= '0;
            cnt_reg       <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ndig_reg      <= ndig_next;
            chunk_reg     <= chunk_next;
            cnt_reg       <= cnt_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (cmd.load)
        begin
            cmd_reg   <= cmd_e_t'(command);
            neg_reg   <= in_neg;
            zp_reg    <= zero_pad;
            width_reg <= CTW'(width_sat);
        end
        if (dig_wr)
        begin
            dig_reg[ndig_reg[DIG_IW-1:0]] <= dig_wdata;
        end
        if (cmd.emit)
        begin
            out_char_reg <= emit_char;
            last_reg     <= (cnt_reg == '0);
        end
    end

    assign st.dig_done = dig_wr;
    assign st.quo_zero = quo_zero;
    assign st.cnt_zero = (cnt_reg == '0);
    assign st.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

    a_rem_below_ten: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < 4'd10))
        else $error("partial remainder out of range");

    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        dig_wr |-> (ndig_reg < NDW'(DIG_N)))
        else $error("digit store overflow");

    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (out_valid_reg && (last_reg == $past(cnt_reg == '0))))
        else $error("last flag does not match the final position");

endmodule

>>> sv/integer_text_formatter.sv
// Top level of the integer text formatter: controller plus datapath.
//
// Input channel (in_valid/in_ready) carries one conversion request per beat:
// command (signed decimal, unsigned decimal, lower-case hex, character), value,
// zero_pad and min_width. Output channel (out_valid/out_ready) carries one
// ASCII character per beat, leftmost first, with last set on the final one.
// Text is right-aligned in a field of min_width characters (saturated at
// MAX_WIDTH); zero padding puts a minus sign in front of the zeros.
//
// Timing: one request at a time. After acceptance the digits are produced
// least significant first. Each decimal digit takes a pass over the
// ceil(VALUE_BITS/8) quotient chunks, since the divide-by-ten unit consumes
// eight quotient bits per cycle; a hex digit or a character comes from a
// single shift or copy. A setup state follows, then one character per cycle
// while the receiver takes them.
// in_ready is high only while the block is idle; the last character may still
// sit in the output register when the next request is taken.
// Reset clears the controller and output valid; no clearing pass is needed.
// When out_ready is low, the output register holds its beat and emission stalls.
module integer_text_formatter #(
    parameter int MAX_WIDTH  = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] value,
    input  logic        zero_pad,
    input  logic [5:0]  min_width,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        last
);
    import itf_pkg::*;

    ctl_cmd_t ctl_cmd;
    dp_stat_t dp_stat;

    // Sequence the request through conversion and emission
    itf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (ctl_cmd),
        .st       (dp_stat)
    );

    // Hold operand, digits and the output register
    itf_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (ctl_cmd),
        .st          (dp_stat),
        .command     (command),
        .value       (value),
        .zero_pad    (zero_pad),
        .min_width   (min_width),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last        (last)
    );

endmodule

>>> tb/tb_integer_text_formatter.sv
// Self-checking testbench for the integer text formatter: randomized requests, checked characters.
`timescale 1ns / 1ps

module tb_integer_text_formatter;

    import itf_pkg::*;

    localparam int MAX_W        = 32;    // field width saturation point of the block
    localparam int HOLD_CYCLES  = 300;   // long output hold-off that backs the block up
    localparam int STALL_LIMIT  = 4000;  // cycles with no beat on either side before giving up
    localparam int TAIL_CYCLES  = 200;   // quiet time after the last character
    localparam int PHASE_ITEMS  = 115;   // random requests per idling phase

    // One request as the sender will offer it, plus how the run behaves around it.
    typedef struct {
        cmd_e_t       cmd;
        logic [31:0]  val;
        logic         zp;
        logic [5:0]   fw;
        int unsigned  tx_idle;   // percent of cycles the sender sits idle
        int unsigned  rx_stall;  // percent of cycles the receiver stalls
        bit           drain;     // hold this request until all text is out
        bit           hold_rx;   // start a long receiver hold-off when offered
    } fmt_req_t;

    // One expected output beat.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = CMD_SDEC;
    logic [31:0] value = '0;
    logic        zero_pad = 1'b0;
    logic [5:0]  min_width = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_char;
    logic        last;

    fmt_req_t    requests_to_send[$];
    char_beat_t  expected_chars[$];

    logic        in_taken = 1'b0;      // request beat accepted at the last rising edge
    logic        rx_hold_req = 1'b0;   // sender asks the receiver for a long hold-off
    int unsigned rx_stall_pct = 0;
    int          hold_left = 0;
    int          idle_cycles = 0;
    int          n_requests = 0;
    int          n_chars = 0;
    int          n_errors = 0;
    bit          timed_out = 1'b0;

    integer_text_formatter #(
        .MAX_WIDTH  (32),
        .VALUE_BITS (32)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .value       (value),
        .zero_pad    (zero_pad),
        .min_width   (min_width),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last        (last)
    );

    always #10 clk = ~clk;

    // Expand one request into the characters it must produce and queue them.
    // Digits are built least significant first and pushed to the front, so
    // the text comes out leftmost first; a zero value still yields one digit.
    function automatic void format_text(input cmd_e_t cmd, input logic [31:0] val,
                                        input logic zp, input logic [5:0] fw);
        logic [7:0]  body[$];
        logic [7:0]  line[$];
        logic [31:0] mag;
        logic [31:0] radix;
        logic [3:0]  d;
        logic [7:0]  fill;
        bit          neg;
        int          width;
        int          padn;
        char_beat_t  beat;
        width = (fw > MAX_W) ? MAX_W : int'(fw);
        neg   = (cmd == CMD_SDEC) && val[31];
        mag   = neg ? (~val + 32'd1) : val;
        radix = (cmd == CMD_HEX) ? 32'd16 : 32'd10;
        if (cmd == CMD_CHAR)
        begin
            body.push_back(val[7:0]);
        end
        else
        begin
            do
            begin
                d = 4'(mag % radix);
                body.push_front((d < 4'd10) ? CH_ZERO + 8'(d) : CH_LOW_A + 8'(d) - 8'd10);
                mag = mag / radix;
            end while (mag != 0);
            if (neg)
            begin
                body.push_front(CH_MINUS);
            end
        end
        // The character kind always pads with spaces.
        fill = (zp && cmd != CMD_CHAR) ? CH_ZERO : CH_SPACE;
        padn = (width > body.size()) ? width - body.size() : 0;
        repeat (padn) line.push_back(fill);
        foreach (body[i]) line.push_back(body[i]);
        // Move the minus sign in front of the zeros.
        if (neg && fill == CH_ZERO && padn > 0)
        begin
            line[0]    = CH_MINUS;
            line[padn] = CH_ZERO;
        end
        foreach (line[i])
        begin
            beat.ch   = line[i];
            beat.last = (i == line.size() - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    function automatic void queue_request(input cmd_e_t cmd, input logic [31:0] val,
                                          input logic zp, input logic [5:0] fw,
                                          input int unsigned tx, input int unsigned rx,
                                          input bit drain, input bit hold_rx);
        fmt_req_t r;
        r.cmd = cmd;   r.val = val;     r.zp = zp;       r.fw = fw;
        r.tx_idle = tx; r.rx_stall = rx; r.drain = drain; r.hold_rx = hold_rx;
        requests_to_send.push_back(r);
    endfunction

    // Pick an operand: full range, small, near powers of ten, small negatives,
    // the sign and hex digit boundaries, or random magnitudes of every length.
    function automatic logic [31:0] rand_operand();
        logic [31:0] p;
        logic [31:0] v;
        p = 32'd1;
        case ($urandom_range(0, 5))
            0: v = $urandom();
            1: v = $urandom_range(0, 20);
            2:
            begin
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                v = p + $urandom_range(0, 2) - 32'd1;
            end
            3: v = -$urandom_range(1, 300);
            4:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'hffff_ffff;
                    default: v = 32'h0000_000f + $urandom_range(0, 1);
                endcase
            end
            default: v = $urandom() >> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    // Mostly widths near the text length, some wide and saturating ones.
    function automatic logic [5:0] rand_width();
        return ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 12));
    endfunction

    // Request driver: change inputs on the falling edge. Once in_valid is up,
    // hold it and the payload until the beat is taken; after that either offer
    // the next request right away or drop valid while the sender idles.
    always @(negedge clk)
    begin : drive_requests
        fmt_req_t nxt;
        bit       offer;
        offer = 1'b0;
        if (rst_n && (!in_valid || in_taken) && requests_to_send.size() > 0)
        begin
            offer = 1'b1;
            if (requests_to_send[0].drain && expected_chars.size() != 0)
            begin
                offer = 1'b0;
            end
            else if ($urandom_range(0, 99) < requests_to_send[0].tx_idle)
            begin
                offer = 1'b0;
            end
        end
        if (offer)
        begin
            nxt = requests_to_send.pop_front();
            command      <= nxt.cmd;
            value        <= nxt.val;
            zero_pad     <= nxt.zp;
            min_width    <= nxt.fw;
            rx_stall_pct <= nxt.rx_stall;
            in_valid     <= 1'b1;
        end
        else if (!in_valid || in_taken)
        begin
            in_valid <= 1'b0;
        end
        rx_hold_req <= offer && nxt.hold_rx;
    end

    // Character receiver: stall at random, or hold off for a long stretch on
    // request so the block backs up and stops taking new requests.
    always @(negedge clk)
    begin : drive_ready
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (rx_hold_req)
        begin
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Monitor: sample both channels on the rising edge. An accepted request
    // queues its text; an accepted character is checked against the oldest
    // expected beat.
    always @(posedge clk)
    begin : watch_ports
        char_beat_t want;
        if (!rst_n)
        begin
            in_taken    <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                format_text(cmd_e_t'(command), value, zero_pad, min_width);
                n_requests++;
            end
            if (out_valid && out_ready)
            begin
                n_chars++;
                if (expected_chars.size() == 0)
                begin
                    $error("out_char: expected nothing, got 0x%02h (last %0b)", out_char, last);
                    n_errors++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_char !== want.ch)
                    begin
                        $error("out_char: expected 0x%02h, got 0x%02h", want.ch, out_char);
                        n_errors++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, last);
                        n_errors++;
                    end
                end
            end
            // Watchdog: count cycles with no beat on either channel.
            idle_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin : run_test
        int unsigned tx_pct[4];
        int unsigned rx_pct[4];
        tx_pct = '{0, 72, 0, 26};
        rx_pct = '{0, 0, 72, 26};

        // Directed requests: extremes of every field, every command and the
        // corner cases of padding, sign placement and saturation.
        queue_request(CMD_SDEC, 32'd0,          1'b0, 6'd0,  0, 0, 1'b0, 1'b0);
        queue_request(CMD_SDEC, 32'hffff_ffff,  1'b0, 6'd0,  0, 0, 1'b0, 1'b0);
        queue_request(CMD_SDEC, 32'h8000_0000,  1'b0, 6'd0,  0, 0, 1'b0, 1'b0);
        queue_request(CMD_SDEC, 32'h8000_0000,  1'b1, 6'd32, 0, 0, 1'b0, 1'b0);
        queue_request(CMD_SDEC, 32'h7fff_ffff,  1'b0, 6'd63, 0, 0, 1'b0, 1'b0);
        queue_request(CMD_SDEC, -32'sd42,       1'b1, 6'd8,  0, 0, 1'b0, 1'b0);
        queue_request(CMD_SDEC, -32'sd42,       1'b0, 6'd8,  0, 0, 1'b0, 1'b0);
        queue_request(CMD_SDEC, -32'sd5,        1'b1, 6'd2,  0, 0, 1'b0, 1'b0);
        queue_request(CMD_SDEC, -32'sd5,        1'b1, 6'd3,  0, 0, 1'b0, 1'b0);
        queue_request(CMD_UDEC, 32'hffff_ffff,  1'b1, 6'd10, 0, 0, 1'b0, 1'b0);
        queue_request(CMD_UDEC, 32'd0,          1'b1, 6'd32, 0, 0, 1'b0, 1'b0);
        queue_request(CMD_UDEC, 32'd9,          1'b0, 6'd0,  0, 0, 1'b0, 1'b0);
        queue_request(CMD_UDEC, 32'd10,         1'b0, 6'd1,  0, 0, 1'b0, 1'b0);
        queue_request(CMD_UDEC, 32'd7,          1'b1, 6'd63, 0, 0, 1'b0, 1'b0);
        queue_request(CMD_HEX,  32'hffff_ffff,  1'b0, 6'd0,  0, 0, 1'b0, 1'b0);
        queue_request(CMD_HEX,  32'hdead_beef,  1'b1, 6'd12, 0, 0, 1'b0, 1'b0);
        queue_request(CMD_HEX,  32'd16,         1'b0, 6'd0,  0, 0, 1'b0, 1'b0);
        queue_request(CMD_HEX,  32'd15,         1'b0, 6'd33, 0, 0, 1'b0, 1'b0);
        queue_request(CMD_HEX,  32'd0,          1'b1, 6'd1,  0, 0, 1'b0, 1'b0);
        queue_request(CMD_CHAR, 32'h0000_0000,  1'b0, 6'd0,  0, 0, 1'b0, 1'b0);
        queue_request(CMD_CHAR, 32'h0000_0025,  1'b1, 6'd5,  0, 0, 1'b0, 1'b0);
        queue_request(CMD_CHAR, 32'hffff_ff41,  1'b1, 6'd1,  0, 0, 1'b0, 1'b0);
        queue_request(CMD_CHAR, 32'h0000_00ff,  1'b0, 6'd32, 0, 0, 1'b0, 1'b0);

        // Random requests in four idling phases. Open each phase with a drained
        // pause, and drop a long receiver hold-off into the first and last.
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                queue_request(cmd_e_t'($urandom_range(0, 3)), rand_operand(),
                              1'($urandom_range(0, 1)), rand_width(),
                              tx_pct[ph], rx_pct[ph],
                              (k == 0) || ($urandom_range(0, 99) < 3),
                              (k == 10 && (ph == 0 || ph == 3)));
            end
        end

        // Hold reset, then release it on a falling edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait until every request is taken and all its text has come out.
        while (!timed_out &&
               !(requests_to_send.size() == 0 && !in_valid && expected_chars.size() == 0))
        begin
            @(posedge clk);
            if (idle_cycles >= STALL_LIMIT)
            begin
                timed_out = 1'b1;
            end
        end

        if (timed_out)
        begin
            $display("timeout: no beat for %0d cycles, %0d characters outstanding",
                     STALL_LIMIT, expected_chars.size());
            $display("integer_text_formatter: mismatch");
            $finish;
        end
        else
        begin
            // Let any stray character surface before the verdict.
            repeat (TAIL_CYCLES) @(posedge clk);
            $display("ran %0d requests over all four commands and widths 0..63, %0d characters",
                     n_requests, n_chars);
            $display("idle phases: none, sender, receiver, both; long hold-offs and drains");
            if (n_errors == 0)
            begin
                $display("integer_text_formatter: match");
            end
            else
            begin
                $display("integer_text_formatter: mismatch");
            end
            $finish;
        end
    end

endmodule

>>> filelist.f
sv/itf_pkg.sv
sv/itf_ctrl.sv
sv/itf_dp.sv
sv/integer_text_formatter.sv
tb/tb_integer_text_formatter.sv
